@@ src/mvm_pkg.sv @@
// mvm_pkg: shared types and constants of the matrix-vector multiply block
// no dependencies; used by every module in src
package mvm_pkg;

    // sizes
    localparam int MAX_COLUMNS  = 256;
    localparam int DATA_WIDTH   = 16;
    localparam int ACC_WIDTH    = 40;
    localparam int ROW_WIDTH    = 16;
    localparam int COL_WIDTH    = $clog2(MAX_COLUMNS);
    localparam int NCOL_WIDTH   = $clog2(MAX_COLUMNS + 1);
    localparam int PROD_WIDTH   = 2 * DATA_WIDTH;

    // configuration port
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;
    localparam logic [NCOL_WIDTH-1:0] NUM_COLUMNS_RESET = NCOL_WIDTH'(MAX_COLUMNS);

    // input operation codes
    localparam logic OP_LOAD_VECTOR = 1'b0;
    localparam logic OP_MATRIX      = 1'b1;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // what a pipeline token does at the accumulator
    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_CLEAR,
        KIND_MAC,
        KIND_ERR
    } t_kind;

    typedef struct packed {
        logic                          operation;
        logic signed [DATA_WIDTH-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0]   row_sum;
        logic [ROW_WIDTH-1:0]          row_index;
        logic                          status;
    } t_out_item;

    // token from the front end to the multiply-accumulate stages
    typedef struct packed {
        t_kind                         kind;
        logic                          last;
        logic [ROW_WIDTH-1:0]          row_index;
        logic signed [DATA_WIDTH-1:0]  value;
    } t_token;

endpackage

@@ src/matrix_vector_multiply_top.sv @@
// matrix_vector_multiply_top: fixed-point matrix-vector product, Q8.8 in, Q24.16 out
// result path: the element that causes a result passes the token, product and result registers in turn
// throughput: one item per cycle while results are taken, set by the single multiplier stage and one store access
// reset: i_rst_n synchronous active low; counters and accumulator clear, column count 256
// depends on mvm_pkg, mvm_cfg, mvm_front, mvm_mac
module matrix_vector_multiply_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mvm_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [mvm_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [mvm_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  mvm_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output mvm_pkg::t_out_item                    o_out_item
);

    logic [mvm_pkg::NCOL_WIDTH-1:0]        ncols;
    logic                                  tok_valid;
    logic                                  tok_ready;
    mvm_pkg::t_token                       tok;
    logic signed [mvm_pkg::DATA_WIDTH-1:0] vec_data;

    // configuration register
    mvm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ncols (ncols)
    );

    // store and counters
    mvm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ncols     (ncols),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_tok_valid (tok_valid),
        .i_tok_ready (tok_ready),
        .o_tok       (tok),
        .o_vec_data  (vec_data)
    );

    // multiply, accumulate and result
    mvm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .o_tok_ready (tok_ready),
        .i_tok       (tok),
        .i_vec_data  (vec_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ src/mvm_cfg.sv @@
// mvm_cfg: APB register for the column count, with range clamping
// depends on mvm_pkg
module mvm_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mvm_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [mvm_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [mvm_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready,
    output logic [mvm_pkg::NCOL_WIDTH-1:0]        o_ncols
);

    logic [mvm_pkg::NCOL_WIDTH-1:0] r_num_columns;
    logic                           sel_reg;

    // register 0 sits at word address 0
    assign sel_reg = (paddr[2] == 1'b0);
    assign pready  = 1'b1;

    // write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_columns <= mvm_pkg::NUM_COLUMNS_RESET;
        end else if (psel && penable && pwrite && sel_reg) begin
            r_num_columns <= pwdata[mvm_pkg::NCOL_WIDTH-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (sel_reg) begin
            prdata[mvm_pkg::NCOL_WIDTH-1:0] = r_num_columns;
        end
    end

    // zero acts as one, anything above the store size acts as the store size
    always_comb begin
        if (r_num_columns == '0) begin
            o_ncols = mvm_pkg::NCOL_WIDTH'(1);
        end else if (r_num_columns > mvm_pkg::NCOL_WIDTH'(mvm_pkg::MAX_COLUMNS)) begin
            o_ncols = mvm_pkg::NCOL_WIDTH'(mvm_pkg::MAX_COLUMNS);
        end else begin
            o_ncols = r_num_columns;
        end
    end

endmodule

@@ src/mvm_front.sv @@
// mvm_front: input stage; vector store, element/column/row counters, token issue
// depends on mvm_pkg
module mvm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [mvm_pkg::NCOL_WIDTH-1:0]        i_ncols,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  mvm_pkg::t_in_item                     i_in_item,
    output logic                                  o_tok_valid,
    input  logic                                  i_tok_ready,
    output mvm_pkg::t_token                       o_tok,
    output logic signed [mvm_pkg::DATA_WIDTH-1:0] o_vec_data
);

    logic signed [mvm_pkg::DATA_WIDTH-1:0] r_store [mvm_pkg::MAX_COLUMNS];
    logic signed [mvm_pkg::DATA_WIDTH-1:0] r_rd_data;
    logic [mvm_pkg::NCOL_WIDTH-1:0]        r_vec_count;
    logic [mvm_pkg::COL_WIDTH-1:0]         r_col;
    logic [mvm_pkg::ROW_WIDTH-1:0]         r_row;
    logic                                  r_tok_valid;
    mvm_pkg::t_token                       r_tok;

    logic                                  in_go;
    logic                                  vec_full;
    logic                                  row_last;
    logic                                  is_load;
    logic [mvm_pkg::COL_WIDTH-1:0]         wr_idx;

    assign o_in_ready = !r_tok_valid || i_tok_ready;
    assign in_go      = i_in_valid && o_in_ready;
    assign is_load    = (i_in_item.operation == mvm_pkg::OP_LOAD_VECTOR);
    assign vec_full   = (r_vec_count >= i_ncols);
    assign row_last   = ({1'b0, r_col} + mvm_pkg::NCOL_WIDTH'(1)) >= i_ncols;
    assign wr_idx     = vec_full ? '0 : r_vec_count[mvm_pkg::COL_WIDTH-1:0];

    // vector store: write on a load transfer, read the current column otherwise
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            if (is_load) begin
                r_store[wr_idx] <= i_in_item.value;
            end else begin
                r_rd_data <= r_store[r_col];
            end
        end
    end

    // counters and token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_count <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_tok_valid <= 1'b0;
        end else begin
            if (in_go) begin
                r_tok_valid <= 1'b1;
            end else if (i_tok_ready) begin
                r_tok_valid <= 1'b0;
            end
            if (in_go) begin
                if (is_load) begin
                    if (vec_full) begin
                        r_vec_count <= mvm_pkg::NCOL_WIDTH'(1);
                        r_col       <= '0;
                        r_row       <= '0;
                    end else begin
                        r_vec_count <= r_vec_count + mvm_pkg::NCOL_WIDTH'(1);
                    end
                end else if (vec_full) begin
                    if (row_last) begin
                        r_col <= '0;
                        r_row <= r_row + mvm_pkg::ROW_WIDTH'(1);
                    end else begin
                        r_col <= r_col + mvm_pkg::COL_WIDTH'(1);
                    end
                end
            end
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_tok.value     <= i_in_item.value;
            r_tok.row_index <= r_row;
            r_tok.last      <= row_last;
            if (is_load) begin
                r_tok.kind <= vec_full ? mvm_pkg::KIND_CLEAR : mvm_pkg::KIND_NOP;
            end else begin
                r_tok.kind <= vec_full ? mvm_pkg::KIND_MAC : mvm_pkg::KIND_ERR;
            end
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;
    assign o_vec_data  = r_rd_data;

endmodule

@@ src/mvm_mac.sv @@
// mvm_mac: product register, 40-bit accumulator and result register
// depends on mvm_pkg
module mvm_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_tok_valid,
    output logic                                  o_tok_ready,
    input  mvm_pkg::t_token                       i_tok,
    input  logic signed [mvm_pkg::DATA_WIDTH-1:0] i_vec_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output mvm_pkg::t_out_item                    o_out_item
);

    logic                                  r_p_valid;
    mvm_pkg::t_kind                        r_p_kind;
    logic                                  r_p_last;
    logic [mvm_pkg::ROW_WIDTH-1:0]         r_p_row;
    logic signed [mvm_pkg::PROD_WIDTH-1:0] r_prod;
    logic signed [mvm_pkg::ACC_WIDTH-1:0]  r_acc;
    logic                                  r_out_valid;
    mvm_pkg::t_out_item                    r_out;

    logic                                  out_free;
    logic                                  has_result;
    logic                                  p_go;
    logic signed [mvm_pkg::ACC_WIDTH-1:0]  sum;

    assign out_free    = !r_out_valid || i_out_ready;
    assign has_result  = (r_p_kind == mvm_pkg::KIND_ERR) ||
                         ((r_p_kind == mvm_pkg::KIND_MAC) && r_p_last);
    assign p_go        = r_p_valid && (!has_result || out_free);
    assign o_tok_ready = !r_p_valid || p_go;
    assign sum         = r_acc + mvm_pkg::ACC_WIDTH'(r_prod);

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_tok_valid && o_tok_ready) begin
            r_p_valid <= 1'b1;
        end else if (p_go) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_valid && o_tok_ready) begin
            r_p_kind <= i_tok.kind;
            r_p_last <= i_tok.last;
            r_p_row  <= i_tok.row_index;
            r_prod   <= i_tok.value * i_vec_data;
        end
    end

    // accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (p_go && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (p_go) begin
                case (r_p_kind)
                    mvm_pkg::KIND_CLEAR: r_acc <= '0;
                    mvm_pkg::KIND_MAC:   r_acc <= r_p_last ? '0 : sum;
                    default:             r_acc <= r_acc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_go && has_result) begin
            r_out.row_index <= r_p_row;
            if (r_p_kind == mvm_pkg::KIND_ERR) begin
                r_out.row_sum <= '0;
                r_out.status  <= mvm_pkg::STATUS_MISMATCH;
            end else begin
                r_out.row_sum <= sum;
                r_out.status  <= mvm_pkg::STATUS_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
